FILE: rtl/lsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    // Field widths
    localparam int IdW      = 16;
    localparam int TimeW    = 32;
    localparam int CntW     = 6;
    localparam int EntryW   = IdW + TimeW;
    localparam int InDataW  = 48;
    localparam int OutDataW = 56;

    // Default stack depth (range 2 to 63, bounded by the 6-bit depth field)
    localparam int DepthDefault = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_SCAN,
        BK_MOVE,
        BK_FINAL,
        BK_NOTFOUND
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] tm;
    } cmd_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] tm;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic             moved;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] tm;
        logic [CntW-1:0]  depth;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/lsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lsr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lsr_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [lsr_pkg::InDataW-1:0]   s_axis_tdata,  // pkt_id, arrival_time
    input  wire logic [1:0]                    s_axis_tuser,  // cmd
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output lsr_pkg::cmd_t                      q_cmd
);

    import lsr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push, pop;

    // Classify the incoming item
    always_comb
    begin
        in_cmd.op = op_t'(s_axis_tuser);
        in_cmd.id = s_axis_tdata[IdW-1:0];
        in_cmd.tm = s_axis_tdata[IdW +: TimeW];
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_cmd         = slot_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lsr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lsr_back #(
    parameter int DEPTH = lsr_pkg::DepthDefault
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire lsr_pkg::cmd_t q_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lsr_pkg::res_t      out_res
);

    import lsr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    back_state_t      state_reg, state_next;
    logic [CntW-1:0]  n_reg, n_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [IdW-1:0]   key_reg, key_next;
    entry_t           hit_reg, hit_next;
    logic             is_pop_reg, is_pop_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             can_emit;
    logic             emit;
    res_t             emit_res;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    entry_t           wdata;
    logic [EntryW-1:0] rdata;
    entry_t           rd_entry;
    logic [CntW-1:0]  n_dec, ptr_ext, ptr_inc;
    logic [AW-1:0]    top_addr;
    logic             more;

    lsr_ram #(
        .WIDTH(EntryW),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_entry = entry_t'(rdata);
    assign can_emit = !out_valid_reg || out_ready;
    assign n_dec    = n_reg - CntW'(1);
    assign top_addr = n_dec[AW-1:0];
    assign ptr_ext  = CntW'(ptr_reg);
    assign ptr_inc  = ptr_ext + CntW'(1);
    assign more     = (ptr_inc < n_reg);

    // Sequence one command at a time
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        ptr_next    = ptr_reg;
        key_next    = key_reg;
        hit_next    = hit_reg;
        is_pop_next = is_pop_reg;
        q_ready     = 1'b0;
        emit        = 1'b0;
        emit_res    = '0;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = rd_entry;
        re          = 1'b0;
        raddr       = ptr_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_PUSH:
                        begin
                            if (can_emit)
                            begin
                                q_ready        = 1'b1;
                                emit           = 1'b1;
                                emit_res.last  = 1'b1;
                                if (n_reg >= CntW'(DEPTH))
                                begin
                                    emit_res.status = ST_FULL;
                                    emit_res.depth  = n_reg;
                                end
                                else
                                begin
                                    we              = 1'b1;
                                    waddr           = n_reg[AW-1:0];
                                    wdata.id        = q_cmd.id;
                                    wdata.tm        = q_cmd.tm;
                                    n_next          = n_reg + CntW'(1);
                                    emit_res.status = ST_OK;
                                    emit_res.depth  = n_reg + CntW'(1);
                                end
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (n_reg == '0)
                            begin
                                if (can_emit)
                                begin
                                    q_ready         = 1'b1;
                                    emit            = 1'b1;
                                    emit_res.status = ST_EMPTY;
                                    emit_res.last   = 1'b1;
                                end
                            end
                            else
                            begin
                                q_ready     = 1'b1;
                                re          = 1'b1;
                                raddr       = top_addr;
                                is_pop_next = (q_cmd.op == OP_POP);
                                state_next  = BK_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (n_reg == '0)
                            begin
                                if (can_emit)
                                begin
                                    q_ready         = 1'b1;
                                    emit            = 1'b1;
                                    emit_res.status = ST_NOTFOUND;
                                    emit_res.depth  = n_reg;
                                    emit_res.last   = 1'b1;
                                end
                            end
                            else
                            begin
                                q_ready    = 1'b1;
                                key_next   = q_cmd.id;
                                re         = 1'b1;
                                raddr      = top_addr;
                                ptr_next   = top_addr;
                                state_next = BK_SCAN;
                            end
                        end
                        default:
                        begin
                            q_ready = 1'b0;
                        end
                    endcase
                end
            end

            BK_READ:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_res.status = ST_OK;
                    emit_res.id     = rd_entry.id;
                    emit_res.tm     = rd_entry.tm;
                    emit_res.depth  = is_pop_reg ? n_dec : n_reg;
                    emit_res.last   = 1'b1;
                    n_next          = is_pop_reg ? n_dec : n_reg;
                    state_next      = BK_IDLE;
                end
            end

            // Walk down from the top, one entry a cycle
            BK_SCAN:
            begin
                if (rd_entry.id == key_reg)
                begin
                    hit_next = rd_entry;
                    if (more)
                    begin
                        re         = 1'b1;
                        raddr      = ptr_inc[AW-1:0];
                        ptr_next   = ptr_inc[AW-1:0];
                        state_next = BK_MOVE;
                    end
                    else
                    begin
                        state_next = BK_FINAL;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    state_next = BK_NOTFOUND;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = AW'(ptr_reg - AW'(1));
                    ptr_next = AW'(ptr_reg - AW'(1));
                end
            end

            // Drop each entry above the hit one place and report it
            BK_MOVE:
            begin
                if (can_emit)
                begin
                    we              = 1'b1;
                    waddr           = AW'(ptr_reg - AW'(1));
                    wdata           = rd_entry;
                    emit            = 1'b1;
                    emit_res.status = ST_OK;
                    emit_res.moved  = 1'b1;
                    emit_res.id     = rd_entry.id;
                    emit_res.tm     = rd_entry.tm;
                    emit_res.depth  = n_dec;
                    if (more)
                    begin
                        re       = 1'b1;
                        raddr    = ptr_inc[AW-1:0];
                        ptr_next = ptr_inc[AW-1:0];
                    end
                    else
                    begin
                        state_next = BK_FINAL;
                    end
                end
            end

            BK_FINAL:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_res.status = ST_OK;
                    emit_res.id     = hit_reg.id;
                    emit_res.tm     = hit_reg.tm;
                    emit_res.depth  = n_dec;
                    emit_res.last   = 1'b1;
                    n_next          = n_dec;
                    state_next      = BK_IDLE;
                end
            end

            BK_NOTFOUND:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_res.status = ST_NOTFOUND;
                    emit_res.depth  = n_reg;
                    emit_res.last   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = emit_res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        hit_reg    <= hit_next;
        is_pop_reg <= is_pop_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

FILE: rtl/lifo_stack_with_remove_by_id_unit.sv
// LIFO stack of packet entries (16-bit id, 32-bit Q16.16 arrival time) with
// removal by id.
// Input channel s_axis: tuser carries the command (push, pop, peek, remove),
// tdata the packet id and arrival time. Output channel m_axis: one item per
// result, tuser flags an entry put back during a removal, tlast marks the
// final result of a command.
// Commands pass a two-item queue in the front end, so the input keeps taking
// items, until the queue is full, while the back end works or the output is stalled.
// Push: a single step in the back end. Pop and peek: a registered read of the
// entry store, then the result. Remove: issue the first read, scan entries
// from the top down, then move each entry above the hit down one place,
// plus the final status; the entry store gives one read per cycle. Results
// leave through the output register.
// Reset empties the stack and drops queued commands and pending results; the
// entry store itself is not cleared. While an item waits on the port with
// m_axis_tready low, it stays there and the back end holds any emitting step.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_remove_by_id_unit #(
    parameter int DEPTH = lsr_pkg::DepthDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [lsr_pkg::InDataW-1:0]  s_axis_tdata,  // pkt_id, arrival_time
    input  wire logic [1:0]                   s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lsr_pkg::OutDataW-1:0]      m_axis_tdata,  // status, out_id, out_time, depth_now
    output logic                              m_axis_tuser,  // moved
    output logic                              m_axis_tlast
);

    import lsr_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    lsr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd)
    );

    lsr_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_res  (res)
    );

    // Pack the result item
    assign m_axis_tdata = {res.depth, res.tm, res.id, res.status};
    assign m_axis_tuser = res.moved;
    assign m_axis_tlast = res.last;

    // Reported depth never exceeds the stack size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.depth <= CntW'(DEPTH)))
        else $error("depth_now beyond stack size");

    // An entry put back is never the final result and always reports ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && res.status == ST_OK))
        else $error("moved result with last or bad status");

    // Only a final result may report a non-ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.status != ST_OK) |-> m_axis_tlast)
        else $error("error status on a non-final result");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lsr_pkg::*;

    localparam int DEPTH      = DepthDefault;
    localparam int NUM_RANDOM = 500;
    localparam int IDLE_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    // Suspend random idling on both sides while set
    bit quiet = 1'b0;
    int stall_cycles = 0;

    // Shadow stack and queue of expected result items
    class stack_scoreboard;
        bit [IdW-1:0]   id_mem [DEPTH];
        bit [TimeW-1:0] tm_mem [DEPTH];
        int   fill;
        res_t expected_q [$];
        int   errors;
        int   n_results;
        int   n_op [4];
        int   n_full;
        int   n_empty;
        int   n_found;
        int   n_missing;
        int   max_moves;

        function new();
            fill = 0;
            errors = 0;
            n_results = 0;
            n_full = 0;
            n_empty = 0;
            n_found = 0;
            n_missing = 0;
            max_moves = 0;
            foreach (n_op[i]) n_op[i] = 0;
        endfunction

        function res_t make_res(status_t st, bit mv, bit [IdW-1:0] id,
                                bit [TimeW-1:0] tm, int depth, bit lst);
            res_t r;
            r.status = st;
            r.moved  = mv;
            r.id     = id;
            r.tm     = tm;
            r.depth  = depth[CntW-1:0];
            r.last   = lst;
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit [IdW-1:0] pick_id();
            return id_mem[$urandom_range(fill - 1)];
        endfunction

        // Apply one accepted command to the shadow stack and queue its results
        function void note_command(op_t op, bit [IdW-1:0] id, bit [TimeW-1:0] tm);
            int hit;
            int top;
            bit [IdW-1:0]   rid;
            bit [TimeW-1:0] rtm;
            n_op[op]++;
            case (op)
                OP_PUSH: begin
                    if (fill >= DEPTH) begin
                        n_full++;
                        expected_q.push_back(make_res(ST_FULL, 1'b0, '0, '0, fill, 1'b1));
                    end
                    else begin
                        id_mem[fill] = id;
                        tm_mem[fill] = tm;
                        fill++;
                        expected_q.push_back(make_res(ST_OK, 1'b0, '0, '0, fill, 1'b1));
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (fill == 0) begin
                        n_empty++;
                        expected_q.push_back(make_res(ST_EMPTY, 1'b0, '0, '0, 0, 1'b1));
                    end
                    else begin
                        top = fill - 1;
                        if (op == OP_POP)
                            fill--;
                        expected_q.push_back(make_res(ST_OK, 1'b0, id_mem[top],
                                                      tm_mem[top], fill, 1'b1));
                    end
                end
                default: begin
                    // Search from the top down for the nearest matching id
                    hit = -1;
                    for (int i = fill - 1; i >= 0; i--) begin
                        if (id_mem[i] == id) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        n_missing++;
                        expected_q.push_back(make_res(ST_NOTFOUND, 1'b0, '0, '0,
                                                      fill, 1'b1));
                    end
                    else begin
                        n_found++;
                        rid = id_mem[hit];
                        rtm = tm_mem[hit];
                        if (fill - 1 - hit > max_moves)
                            max_moves = fill - 1 - hit;
                        // Shift the entries above the hit down, bottom first
                        for (int i = hit + 1; i < fill; i++) begin
                            id_mem[i-1] = id_mem[i];
                            tm_mem[i-1] = tm_mem[i];
                            expected_q.push_back(make_res(ST_OK, 1'b1, id_mem[i],
                                                          tm_mem[i], fill - 1, 1'b0));
                        end
                        fill--;
                        expected_q.push_back(make_res(ST_OK, 1'b0, rid, rtm, fill, 1'b1));
                    end
                end
            endcase
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("%0t ns: mismatch on %s in result %0d: got 0x%0h, want 0x%0h",
                     $time, what, n_results, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            n_results++;
            if (expected_q.size() == 0) begin
                report("unexpected item", got, 0);
            end
            else begin
                want = expected_q.pop_front();
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.moved != want.moved) report("moved", got.moved, want.moved);
                if (got.id != want.id) report("out_id", got.id, want.id);
                if (got.tm != want.tm) report("out_time", got.tm, want.tm);
                if (got.depth != want.depth) report("depth_now", got.depth, want.depth);
                if (got.last != want.last) report("last", got.last, want.last);
            end
        endtask
    endclass

    stack_scoreboard sb;

    lifo_stack_with_remove_by_id_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (!quiet && $urandom_range(99) < 35)
            m_axis_tready = 1'b0;
        else
            m_axis_tready = 1'b1;
    end

    // Unpack and check each accepted result item
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = status_t'(m_axis_tdata[1:0]);
            got.moved  = m_axis_tuser;
            got.id     = m_axis_tdata[17:2];
            got.tm     = m_axis_tdata[49:18];
            got.depth  = m_axis_tdata[55:50];
            got.last   = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Watchdog: end the run after a long stretch with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one command item, idling first at random, and hold it until taken
    task automatic send_cmd(op_t op, bit [IdW-1:0] id, bit [TimeW-1:0] tm);
        int gap;
        if (!quiet && $urandom_range(99) < 35) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {tm, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(op, id, tm);
        @(negedge clk);
    endtask

    initial
    begin
        int   mode;
        int   r;
        op_t  op;
        bit [IdW-1:0] id;

        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty stack: pop, peek and remove all report at once
        send_cmd(OP_POP, 16'h0000, 32'h0);
        send_cmd(OP_PEEK, 16'h0000, 32'h0);
        send_cmd(OP_REMOVE, 16'h0000, 32'h0);
        // Field extremes and a duplicated id
        send_cmd(OP_PUSH, 16'h0000, 32'h0000_0000);
        send_cmd(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH, 16'h1234, 32'h0001_0000);
        send_cmd(OP_PUSH, 16'h0000, 32'h0000_0005);
        send_cmd(OP_PEEK, 16'h0000, 32'h0);
        // Hit in the middle: two entries put back
        send_cmd(OP_REMOVE, 16'hFFFF, 32'h0);
        // Duplicate id: the entry nearest the top goes, nothing moves
        send_cmd(OP_REMOVE, 16'h0000, 32'h0);
        send_cmd(OP_REMOVE, 16'h7777, 32'h0);
        send_cmd(OP_POP, 16'h0000, 32'h0);
        send_cmd(OP_POP, 16'h0000, 32'h0);
        send_cmd(OP_POP, 16'h0000, 32'h0);
        // Hit at the bottom
        send_cmd(OP_PUSH, 16'hA5A5, 32'h5A5A_A5A5);
        send_cmd(OP_PUSH, 16'h5A5A, 32'hA5A5_5A5A);
        send_cmd(OP_REMOVE, 16'hA5A5, 32'hFFFF_FFFF);
        send_cmd(OP_POP, 16'h0000, 32'h0);
        send_cmd(OP_PEEK, 16'hFFFF, 32'hFFFF_FFFF);

        // Random blocks that fill, drain or mix, so full and deep removals occur
        mode = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 25 == 0) begin
                r = $urandom_range(99);
                mode = (r < 40) ? 0 : (r < 70) ? 1 : 2;
            end
            quiet = (n >= 200 && n < 300);
            r = $urandom_range(99);
            case (mode)
                0:       op = (r < 75) ? OP_PUSH : (r < 85) ? OP_REMOVE :
                              (r < 93) ? OP_POP : OP_PEEK;
                1:       op = (r < 10) ? OP_PUSH : (r < 45) ? OP_POP :
                              (r < 85) ? OP_REMOVE : OP_PEEK;
                default: op = (r < 40) ? OP_PUSH : (r < 60) ? OP_POP :
                              (r < 85) ? OP_REMOVE : OP_PEEK;
            endcase
            r = $urandom_range(99);
            if (op == OP_REMOVE && sb.fill > 0 && r < 70)
                id = sb.pick_id();
            else if (r < 85)
                id = IdW'($urandom_range(7));
            else
                id = IdW'($urandom_range(16'hFFFF));
            send_cmd(op, id, $urandom());
        end
        quiet = 1'b0;
        s_axis_tvalid = 1'b0;

        // Drain, then give any stray item time to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 20) @(posedge clk);

        $display("commands: %0d push, %0d pop, %0d peek, %0d remove; %0d results checked",
                 sb.n_op[OP_PUSH], sb.n_op[OP_POP], sb.n_op[OP_PEEK], sb.n_op[OP_REMOVE],
                 sb.n_results);
        $display("full %0d, empty %0d, found %0d, missing %0d, most entries moved %0d",
                 sb.n_full, sb.n_empty, sb.n_found, sb.n_missing, sb.max_moves);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
